>>> hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types, sizes and helpers for the sliding window minimum/maximum block.
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 32;
	// Wide enough to hold WINDOW_MAX itself, as the window register and ages do.
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int CFG_W      = 7;

	localparam logic [CNT_W-1:0] AGE_SAT = {CNT_W{1'b1}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       start_req;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] window_min;
		logic signed [SAMPLE_W-1:0] window_max;
	} out_word_t;

	// One deque slot. The age is the distance to the next sample to arrive.
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] value;
		logic [CNT_W-1:0]           age;
	} entry_t;

	// Control broadcast to every cell of one deque.
	typedef struct packed {
		logic                       step;
		logic                       clear;
		logic signed [SAMPLE_W-1:0] key;
		logic [CNT_W-1:0]           win;
	} ctl_t;

	// Window length as used: zero counts as one, large values saturate.
	function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
		logic [CNT_W-1:0] r;
		if (ws == '0) begin
			r = CNT_W'(1);
		end else if (32'(ws) > WINDOW_MAX) begin
			r = CNT_W'(WINDOW_MAX);
		end else begin
			r = CNT_W'(ws);
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One slot of a monotonic deque, kept as a rising (minimum) deque.
// ----------------------------------------------------------------------------
module swmm_cell
	import swmm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  logic   shift,
	input  logic   keep_left,
	input  entry_t right_nxt,
	output logic   keep,
	output logic   aged,
	output entry_t nxt
);

	logic             valid_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [CNT_W-1:0] age_q;
	logic             ins;
	logic [CNT_W-1:0] age_inc;
	entry_t           sel;

	// An entry survives the tail pop only while it is strictly below the new key.
	assign keep    = valid_q && !ctl.clear && (value_q < ctl.key);
	assign ins     = keep_left && !keep;
	assign aged    = valid_q && (age_q >= ctl.win);
	assign age_inc = (age_q == AGE_SAT) ? age_q : age_q + CNT_W'(1);

	always_comb begin
		nxt = '{valid: valid_q, value: value_q, age: age_q};
		if (ctl.step) begin
			if (keep) begin
				nxt = '{valid: 1'b1, value: value_q, age: age_inc};
			end else if (ins) begin
				nxt = '{valid: 1'b1, value: ctl.key, age: CNT_W'(1)};
			end else begin
				nxt = '{valid: 1'b0, value: value_q, age: age_q};
			end
		end
	end

	assign sel = shift ? right_nxt : nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= sel.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= sel.value;
		age_q   <= sel.age;
	end

endmodule

>>> hw/rtl/swmm_deque.sv
// ----------------------------------------------------------------------------
// swmm_deque
// A row of deque cells with the head at cell zero. Holds a rising deque.
// ----------------------------------------------------------------------------
module swmm_deque
	import swmm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       clear,
	input  logic                       purge,
	input  logic signed [SAMPLE_W-1:0] key,
	input  logic [CNT_W-1:0]           win,
	output logic                       purge_need,
	output logic signed [SAMPLE_W-1:0] head_nxt
);

	ctl_t   ctl;
	logic   shift;
	entry_t nxt   [WINDOW_MAX+1];
	logic   keep  [WINDOW_MAX+1];
	logic   aged  [WINDOW_MAX];

	// Two stale entries at the head cannot both leave in one step, so the
	// oldest is dropped ahead of the sample.
	assign purge_need = aged[0] && aged[1];

	// The slot past the last cell takes the new sample when every cell keeps
	// its entry. It only reaches the row when the row shifts left.
	assign keep[0]          = 1'b1;
	assign nxt[WINDOW_MAX]  = '{valid: step && keep[WINDOW_MAX], value: key,
		age: CNT_W'(1)};

	always_comb begin
		ctl.step  = step;
		ctl.clear = clear;
		ctl.key   = key;
		ctl.win   = win;
	end

	always_comb begin
		if (step) begin
			// A stale head leaves by shifting the row left, unless the new
			// sample empties the deque anyway.
			shift = aged[0] && keep[1];
		end else begin
			shift = purge && purge_need;
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swmm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.shift     (shift),
			.keep_left (keep[i]),
			.right_nxt (nxt[i+1]),
			.keep      (keep[i+1]),
			.aged      (aged[i]),
			.nxt       (nxt[i])
		);
	end

	assign head_nxt = shift ? nxt[1].value : nxt[0].value;

endmodule

>>> hw/rtl/sliding_window_min_max_top.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_top
// Sliding window minimum and maximum over a stream of signed samples.
// ----------------------------------------------------------------------------
// Each input word carries one signed sample; from the word that completes
// window_size samples of the current sequence on, every word yields one
// output word with the minimum and maximum of the last window_size samples.
// A word with start_req set begins a new sequence. The block normally takes
// one word per clock while the output is not stalled: each deque is a row of
// WINDOW_MAX cells that all compare against the new sample in parallel and
// shift by at most one place per cycle. Only after window_size has been
// lowered can several old entries sit at a deque head; then each extra stale
// entry is purged in a stall before the next word is taken. Results sit in an
// output register, so a new word is taken only when no result is pending or
// the previous result is taken in the same cycle. window_size is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block does not enforce; zero acts as one and values above
// WINDOW_MAX act as WINDOW_MAX. Positions are tracked as ages relative to
// the next sample rather than as absolute sample indices.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top
	import swmm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0] window_size_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_nxt;
	logic [CNT_W-1:0] win;
	logic             out_valid_q;
	out_word_t        out_word_q;
	logic             accept;
	logic             purge;
	logic             min_purge_need;
	logic             max_purge_need;
	logic signed [SAMPLE_W-1:0] min_head;
	logic signed [SAMPLE_W-1:0] max_head;

	assign win = eff_window(window_size_q);

	// Stale-head cleanup runs only while a word waits, so later register
	// writes cannot be undone by it.
	assign purge    = in_valid && (min_purge_need || max_purge_need);
	assign in_stall = (out_valid_q && out_stall) || purge;
	assign accept   = in_valid && !in_stall;

	// The maximum deque keeps inverted samples: inversion reverses signed
	// order, so a rising deque of inverted values tracks the maximum.
	swmm_deque u_min (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.clear      (in_word.start_req),
		.purge      (purge),
		.key        (in_word.sample),
		.win        (win),
		.purge_need (min_purge_need),
		.head_nxt   (min_head)
	);

	swmm_deque u_max (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.clear      (in_word.start_req),
		.purge      (purge),
		.key        (~in_word.sample),
		.win        (win),
		.purge_need (max_purge_need),
		.head_nxt   (max_head)
	);

	// The fill count saturates at the largest window.
	always_comb begin
		if (in_word.start_req) begin
			fill_nxt = CNT_W'(1);
		end else if (32'(fill_q) < WINDOW_MAX) begin
			fill_nxt = fill_q + CNT_W'(1);
		end else begin
			fill_nxt = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_W'(1);
			fill_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			if (accept) begin
				fill_q      <= fill_nxt;
				out_valid_q <= (fill_nxt >= win);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q.window_min <= min_head;
			out_word_q.window_max <= ~max_head;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
